/* rtl/core/psmc_pkg.sv */
// Shared types and constants for the pair sum membership counter.
package psmc_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int VALUE_W      = 32;
    localparam int KIND_W       = 2;
    localparam int HIT_W        = 32;
    localparam int STATUS_W     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_CLEAR = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_SRCH,
        ST_INS_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_Q_RD,
        ST_Q_KEY,
        ST_Q_SRCH,
        ST_Q_CMP,
        ST_FINISH
    } eng_state_t;

    typedef struct packed {
        logic             possible;
        logic [HIT_W-1:0] hit_total;
        status_t          status;
    } result_t;

endpackage

/* rtl/core/pair_sum_membership_counter.sv */
// Top level of the pair sum membership counter with its output register.
// Every beat in gives one beat out. Cards sit sorted in a single memory with
// one write and one registered read port, and every step below is bound by
// that read port. A clear, an unused kind or a load into a full store goes
// straight to the result. A load binary searches for its slot, moves each
// larger card up by one place to open that slot, and then writes the new
// card. A query reads each stored card in turn and binary searches for the
// difference, stopping at the first match. The next beat is taken as soon
// as a result has moved to the output register.
module pair_sum_membership_counter
    import psmc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // possible[0], hit_total[32:1], zero pad[39:33]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic    m_tvalid_reg, m_tvalid_next;
    result_t out_reg;

    psmc_engine #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (kind_t'(s_tuser)),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    psmc_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg.hit_total, out_reg.possible};
    assign m_tuser  = out_reg.status;

endmodule

/* rtl/core/psmc_store.sv */
// Card store memory with one write port and one registered read port.
module psmc_store
    import psmc_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [VALUE_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [VALUE_W-1:0] wr_data
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/psmc_engine.sv */
// Sequencer that inserts cards in sorted order and answers pair sum queries.
module psmc_engine
    import psmc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  kind_t              in_kind,
    input  logic [VALUE_W-1:0] in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [VALUE_W-1:0] rd_data,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [VALUE_W-1:0] wr_data
);

    eng_state_t         state_reg, state_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   sp_reg, sp_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [HIT_W-1:0]   hit_reg, hit_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic               found_reg, found_next;
    status_t            status_reg, status_next;

    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    sp_dec;
    logic                search_open;
    logic                store_full;
    logic signed [32:0]  diff;
    logic                diff_in_range;
    logic                card_le_value;
    logic                card_lt_key;
    logic                card_eq_key;

    assign mid           = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sp_dec        = sp_reg - 1'b1;
    assign search_open   = lo_reg < hi_reg;
    assign store_full    = count_reg == CNT_W'(CAPACITY);
    assign diff          = $signed({value_reg[VALUE_W-1], value_reg})
                         - $signed({rd_data[VALUE_W-1], rd_data});
    assign diff_in_range = diff[32] == diff[31];
    assign card_le_value = $signed(rd_data) <= $signed(value_reg);
    assign card_lt_key   = $signed(rd_data) < $signed(key_reg);
    assign card_eq_key   = rd_data == key_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_kind)
                        KIND_LOAD:  state_next = store_full ? ST_FINISH : ST_INS_SRCH;
                        KIND_QUERY: state_next = ST_Q_RD;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_INS_SRCH: state_next = search_open ? ST_INS_CMP : ST_SHIFT_RD;
            ST_INS_CMP:  state_next = ST_INS_SRCH;
            ST_SHIFT_RD: state_next = (sp_reg > lo_reg) ? ST_SHIFT_WR : ST_INS_WR;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_INS_WR:   state_next = ST_FINISH;
            ST_Q_RD:     state_next = (j_reg < count_reg) ? ST_Q_KEY : ST_FINISH;
            ST_Q_KEY:    state_next = diff_in_range ? ST_Q_SRCH : ST_Q_RD;
            ST_Q_SRCH:   state_next = search_open ? ST_Q_CMP : ST_Q_RD;
            ST_Q_CMP:    state_next = card_eq_key ? ST_FINISH : ST_Q_SRCH;
            ST_FINISH:   state_next = res_ready ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = state_reg == ST_IDLE;
        res_valid     = state_reg == ST_FINISH;
        res.possible  = found_reg;
        res.hit_total = hit_reg;
        res.status    = status_reg;
        rd_en         = 1'b0;
        rd_addr       = mid[ADDR_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = sp_reg[ADDR_W-1:0];
        wr_data       = rd_data;
        case (state_reg)
            ST_INS_SRCH: rd_en = search_open;
            ST_Q_SRCH:   rd_en = search_open;
            ST_SHIFT_RD: begin
                rd_en   = sp_reg > lo_reg;
                rd_addr = sp_dec[ADDR_W-1:0];
            end
            ST_SHIFT_WR: wr_en = 1'b1;
            ST_INS_WR: begin
                wr_en   = 1'b1;
                wr_addr = lo_reg[ADDR_W-1:0];
                wr_data = value_reg;
            end
            ST_Q_RD: begin
                rd_en   = j_reg < count_reg;
                rd_addr = j_reg[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        value_next  = value_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        j_next      = j_reg;
        sp_next     = sp_reg;
        count_next  = count_reg;
        hit_next    = hit_reg;
        key_next    = key_reg;
        found_next  = found_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    value_next  = in_value;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    j_next      = '0;
                    found_next  = 1'b0;
                    status_next = STATUS_DONE;
                    case (in_kind)
                        KIND_CLEAR: begin
                            count_next  = '0;
                            hit_next    = '0;
                            status_next = STATUS_CLEAR;
                        end
                        KIND_LOAD: begin
                            if (store_full) begin
                                status_next = STATUS_FULL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INS_SRCH: begin
                if (!search_open) begin
                    sp_next = count_reg;
                end
            end
            ST_INS_CMP: begin
                if (card_le_value) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
            end
            ST_SHIFT_WR: sp_next = sp_dec;
            ST_INS_WR:   count_next = count_reg + 1'b1;
            ST_Q_KEY: begin
                if (diff_in_range) begin
                    key_next = diff[VALUE_W-1:0];
                    lo_next  = '0;
                    hi_next  = count_reg;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_Q_SRCH: begin
                if (!search_open) begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_Q_CMP: begin
                if (card_eq_key) begin
                    found_next = 1'b1;
                    if (hit_reg != '1) begin
                        hit_next = hit_reg + 1'b1;
                    end
                end else if (card_lt_key) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            hit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        j_reg      <= j_next;
        sp_reg     <= sp_next;
        key_reg    <= key_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

endmodule
